>>> rtl/core/ttq_pkg.sv
`default_nettype none

package ttq_pkg;

   localparam int QUEUE_DEPTH     = 16;
   localparam int TIME_BITS       = 48;
   localparam int FIELD_TIME_BITS = 48;
   localparam int TASK_BITS       = 8;
   localparam int IDX_BITS        = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS        = $clog2(QUEUE_DEPTH + 1);

   typedef logic [TIME_BITS-1:0]       ttq_time_type;
   typedef logic [FIELD_TIME_BITS-1:0] ttq_field_time_type;
   typedef logic [TASK_BITS-1:0]       ttq_task_type;
   typedef logic [IDX_BITS-1:0]        ttq_idx_type;
   typedef logic [CNT_BITS-1:0]        ttq_cnt_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POLL = 1'b1
   } ttq_op_type;

   typedef enum logic [2:0] {
      ST_STORED  = 3'd0,
      ST_POPPED  = 3'd1,
      ST_NOT_DUE = 3'd2,
      ST_EMPTY   = 3'd3,
      ST_DROPPED = 3'd4
   } ttq_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_INSERT,
      S_HEAD,
      S_SHIFT_DOWN,
      S_EMIT
   } ttq_state_type;

   typedef struct packed {
      ttq_task_type task_id;
      ttq_time_type due_time;
   } ttq_entry_type;

endpackage

`default_nettype wire

>>> rtl/core/ttq_if.sv
`default_nettype none

interface ttq_req_if;
   logic                        valid;
   logic                        ready;
   ttq_pkg::ttq_op_type         operation;
   ttq_pkg::ttq_field_time_type time_value;
   ttq_pkg::ttq_task_type       task_id;

   modport source (output valid, operation, time_value, task_id, input ready);
   modport sink   (input valid, operation, time_value, task_id, output ready);
endinterface

interface ttq_rsp_if;
   logic                        valid;
   logic                        ready;
   ttq_pkg::ttq_status_type     status;
   ttq_pkg::ttq_task_type       result_task;
   ttq_pkg::ttq_field_time_type result_time;

   modport source (output valid, status, result_task, result_time, input ready);
   modport sink   (input valid, status, result_task, result_time, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ttq_ram.sv
`default_nettype none

module ttq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_address,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_address,
   output logic      [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

   assign read_data = read_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/timed_task_queue.sv
`default_nettype none

// Timed task queue: holds up to QUEUE_DEPTH tasks sorted by due time in a
// single-port-read RAM, one item at a time. A push walks the sorted entries
// one per cycle to find its slot (bumping its time by one on each collision),
// then moves the later entries up one per cycle and writes the item into its
// slot. A push into a full queue is dropped without touching the RAM, and a
// push dropped at the top of the time range stops at the colliding entry.
// A poll answers empty on an empty queue and not due when the head is not
// due; when the head is popped, the remaining entries move down one per cycle.
// The RAM gives one read and one write per cycle. The result sits in an
// output register, so a stalled response only holds the block once the next
// result is ready. No clearing pass after reset: only entries below the fill
// count are ever used.
module timed_task_queue (
   input wire logic clock,
   input wire logic reset,
   ttq_req_if.sink   req_chan,
   ttq_rsp_if.source rsp_chan
);

   ttq_pkg::ttq_state_type  state_ff,      state_in;
   ttq_pkg::ttq_time_type   time_ff,       time_in;
   ttq_pkg::ttq_task_type   task_ff,       task_in;
   ttq_pkg::ttq_cnt_type    pos_ff,        pos_in;
   ttq_pkg::ttq_idx_type    src_ff,        src_in;
   ttq_pkg::ttq_cnt_type    count_ff,      count_in;
   ttq_pkg::ttq_status_type res_status_ff, res_status_in;
   ttq_pkg::ttq_task_type   res_task_ff,   res_task_in;
   ttq_pkg::ttq_time_type   res_time_ff,   res_time_in;

   logic                        out_valid_ff;
   ttq_pkg::ttq_status_type     out_status_ff;
   ttq_pkg::ttq_task_type       out_task_ff;
   ttq_pkg::ttq_field_time_type out_time_ff;

   logic                    ram_we;
   ttq_pkg::ttq_idx_type    ram_waddr;
   ttq_pkg::ttq_entry_type  ram_wdata;
   ttq_pkg::ttq_idx_type    ram_raddr;
   ttq_pkg::ttq_entry_type  ram_rdata;

   logic                 out_free;
   logic                 emit_load;
   ttq_pkg::ttq_cnt_type pos_next;
   ttq_pkg::ttq_idx_type pos_idx;

   ttq_ram #(
      .WIDTH($bits(ttq_pkg::ttq_entry_type)),
      .DEPTH(ttq_pkg::QUEUE_DEPTH)
   ) u_ram (
      .clock        (clock),
      .write_enable (ram_we),
      .write_address(ram_waddr),
      .write_data   (ram_wdata),
      .read_address (ram_raddr),
      .read_data    (ram_rdata)
   );

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign emit_load = (state_ff == ttq_pkg::S_EMIT) && out_free;
   assign pos_next  = pos_ff + 1'b1;
   assign pos_idx   = pos_ff[ttq_pkg::IDX_BITS-1:0];

   assign req_chan.ready       = (state_ff == ttq_pkg::S_IDLE);
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.status      = out_status_ff;
   assign rsp_chan.result_task = out_task_ff;
   assign rsp_chan.result_time = out_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttq_pkg::S_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (emit_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      time_ff       <= time_in;
      task_ff       <= task_in;
      pos_ff        <= pos_in;
      src_ff        <= src_in;
      res_status_ff <= res_status_in;
      res_task_ff   <= res_task_in;
      res_time_ff   <= res_time_in;
      if (emit_load) begin
         out_status_ff <= res_status_ff;
         out_task_ff   <= res_task_ff;
         out_time_ff   <= ttq_pkg::ttq_field_time_type'(res_time_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      task_in       = task_ff;
      pos_in        = pos_ff;
      src_in        = src_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_task_in   = res_task_ff;
      res_time_in   = res_time_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      unique case (state_ff)
         ttq_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               time_in     = ttq_pkg::ttq_time_type'(req_chan.time_value);
               task_in     = req_chan.task_id;
               pos_in      = '0;
               res_task_in = '0;
               res_time_in = '0;
               if (req_chan.operation == ttq_pkg::OP_POLL) begin
                  if (count_ff == '0) begin
                     res_status_in = ttq_pkg::ST_EMPTY;
                     state_in      = ttq_pkg::S_EMIT;
                  end else begin
                     state_in = ttq_pkg::S_HEAD;
                  end
               end else begin
                  if (count_ff == ttq_pkg::ttq_cnt_type'(ttq_pkg::QUEUE_DEPTH)) begin
                     res_status_in = ttq_pkg::ST_DROPPED;
                     state_in      = ttq_pkg::S_EMIT;
                  end else if (count_ff == '0) begin
                     state_in = ttq_pkg::S_INSERT;
                  end else begin
                     state_in = ttq_pkg::S_SCAN;
                  end
               end
            end
         end

         // entry at pos_ff is on the read port
         ttq_pkg::S_SCAN: begin
            if (ram_rdata.due_time > time_ff) begin
               src_in    = ttq_pkg::ttq_idx_type'(count_ff - 1'b1);
               ram_raddr = ttq_pkg::ttq_idx_type'(count_ff - 1'b1);
               state_in  = ttq_pkg::S_SHIFT_UP;
            end else if ((ram_rdata.due_time == time_ff) && (time_ff == '1)) begin
               res_status_in = ttq_pkg::ST_DROPPED;
               res_time_in   = '0;
               state_in      = ttq_pkg::S_EMIT;
            end else begin
               // slot taken: bump the requested time past it
               if (ram_rdata.due_time == time_ff) begin
                  time_in = time_ff + 1'b1;
               end
               pos_in    = pos_next;
               ram_raddr = pos_next[ttq_pkg::IDX_BITS-1:0];
               if (pos_next == count_ff) begin
                  state_in = ttq_pkg::S_INSERT;
               end
            end
         end

         ttq_pkg::S_SHIFT_UP: begin
            ram_we    = 1'b1;
            ram_waddr = src_ff + 1'b1;
            ram_wdata = ram_rdata;
            if (src_ff == pos_idx) begin
               state_in = ttq_pkg::S_INSERT;
            end else begin
               src_in    = src_ff - 1'b1;
               ram_raddr = src_ff - 1'b1;
            end
         end

         ttq_pkg::S_INSERT: begin
            ram_we             = 1'b1;
            ram_waddr          = pos_idx;
            ram_wdata.task_id  = task_ff;
            ram_wdata.due_time = time_ff;
            count_in           = count_ff + 1'b1;
            res_status_in      = ttq_pkg::ST_STORED;
            res_time_in        = time_ff;
            state_in           = ttq_pkg::S_EMIT;
         end

         ttq_pkg::S_HEAD: begin
            res_time_in = ram_rdata.due_time;
            if (ram_rdata.due_time < time_ff) begin
               res_status_in = ttq_pkg::ST_POPPED;
               res_task_in   = ram_rdata.task_id;
               count_in      = count_ff - 1'b1;
               src_in        = ttq_pkg::ttq_idx_type'(1);
               ram_raddr     = ttq_pkg::ttq_idx_type'(1);
               state_in      = (count_ff == ttq_pkg::ttq_cnt_type'(1)) ?
                               ttq_pkg::S_EMIT : ttq_pkg::S_SHIFT_DOWN;
            end else begin
               res_status_in = ttq_pkg::ST_NOT_DUE;
               state_in      = ttq_pkg::S_EMIT;
            end
         end

         // count_ff already holds the reduced count, the old last index
         ttq_pkg::S_SHIFT_DOWN: begin
            ram_we    = 1'b1;
            ram_waddr = src_ff - 1'b1;
            ram_wdata = ram_rdata;
            if (ttq_pkg::ttq_cnt_type'(src_ff) == count_ff) begin
               state_in = ttq_pkg::S_EMIT;
            end else begin
               src_in    = src_ff + 1'b1;
               ram_raddr = src_ff + 1'b1;
            end
         end

         ttq_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = ttq_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ttq_pkg::S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/core/ttq_checker.sv
`default_nettype none

module ttq_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire ttq_pkg::ttq_status_type     rsp_status,
   input wire ttq_pkg::ttq_task_type       rsp_task,
   input wire ttq_pkg::ttq_field_time_type rsp_time
);

   // one item in flight: an accepted request closes the input for a while
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ttq: request accepted while previous item in flight");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_task) && $stable(rsp_time))
      else $error("ttq: stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ttq_pkg::ST_POPPED) |-> rsp_task == '0)
      else $error("ttq: task id on a response that popped nothing");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == ttq_pkg::ST_EMPTY) ||
                    (rsp_status == ttq_pkg::ST_DROPPED)) |-> rsp_time == '0)
      else $error("ttq: nonzero time on empty or dropped response");

endmodule

bind timed_task_queue ttq_checker u_ttq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_task  (rsp_chan.result_task),
   .rsp_time  (rsp_chan.result_time)
);

`default_nettype wire
